// File: rtl/mfrp_pkg.sv
package mfrp_pkg;

    // Field widths
    localparam int FrameBitsW = 25;
    localparam int LetterW    = 8;
    localparam int BytesW     = FrameBitsW - 3;
    localparam int SeqW       = 16;
    localparam int TsW        = 32;
    localparam int SsrcW      = 32;
    localparam int PtW        = 7;
    localparam int PicW       = 3;
    localparam int LenW       = 16;
    localparam int MtuW       = 16;
    localparam int HdrW       = 7;
    localparam int AccumW     = 48;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 32;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CFG_MTU       = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEADER    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PAYLOAD   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SOURCE_ID = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TS_START  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_TICKS     = 3'd5;

    // Register reset values
    localparam logic [MtuW-1:0]  MTU_RESET   = 16'd1500;
    localparam logic [HdrW-1:0]  HDR_RESET   = 7'd16;
    localparam logic [PtW-1:0]   PT_RESET    = 7'd32;
    localparam logic [31:0]      TICKS_RESET = 32'd235929600;

    // Picture letters and type codes
    localparam logic [LetterW-1:0] LETTER_I = 8'h49;
    localparam logic [LetterW-1:0] LETTER_P = 8'h50;
    localparam logic [LetterW-1:0] LETTER_B = 8'h42;
    localparam logic [LetterW-1:0] LETTER_D = 8'h44;

    localparam logic [PicW-1:0] PIC_UNKNOWN = 3'd0;
    localparam logic [PicW-1:0] PIC_I       = 3'd1;
    localparam logic [PicW-1:0] PIC_P       = 3'd2;
    localparam logic [PicW-1:0] PIC_B       = 3'd3;
    localparam logic [PicW-1:0] PIC_D       = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic take;    // input channel ready
        logic calc_q;  // reciprocal multiply for slice quotient
        logic calc_m;  // quotient times slice size
        logic calc_s;  // correction, sliced room
        logic emit;    // issue one packet header
    } mfrp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;   // request waiting on the input channel
        logic empty;      // frame holds no whole byte
        logic last_pkt;   // packet being issued ends the frame
        logic out_stall;  // output register full and not taken
    } mfrp_sts_t;

    function automatic logic [PicW-1:0] kind_of_letter(input logic [LetterW-1:0] c);
        logic [PicW-1:0] k;
        unique case (c)
            LETTER_I: k = PIC_I;
            LETTER_P: k = PIC_P;
            LETTER_B: k = PIC_B;
            LETTER_D: k = PIC_D;
            default:  k = PIC_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/mfrp_if.sv
// Frame descriptor channel
interface mfrp_in_if;
    logic                            valid;
    logic                            ready;
    logic [mfrp_pkg::FrameBitsW-1:0] frame_bits;
    logic [mfrp_pkg::LetterW-1:0]    picture_letter;

    modport source (output valid, frame_bits, picture_letter, input ready);
    modport sink   (input valid, frame_bits, picture_letter, output ready);
endinterface

// Packet header channel
interface mfrp_out_if;
    logic                       valid;
    logic                       ready;
    logic [mfrp_pkg::SeqW-1:0]  sequence_number;
    logic [mfrp_pkg::TsW-1:0]   time_stamp;
    logic [mfrp_pkg::SsrcW-1:0] ssrc_out;
    logic [mfrp_pkg::PtW-1:0]   payload_type_out;
    logic [mfrp_pkg::PicW-1:0]  picture_type;
    logic [mfrp_pkg::LenW-1:0]  payload_length;
    logic                       marker;
    logic                       truncated;
    logic                       last;

    modport source (output valid, sequence_number, time_stamp, ssrc_out, payload_type_out,
                    picture_type, payload_length, marker, truncated, last, input ready);
    modport sink   (input valid, sequence_number, time_stamp, ssrc_out, payload_type_out,
                    picture_type, payload_length, marker, truncated, last, output ready);
endinterface

// Configuration write channel
interface mfrp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mfrp_pkg::CfgIdxW-1:0]  index;
    logic [mfrp_pkg::CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/mfrp_ctrl.sv
module mfrp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  mfrp_pkg::mfrp_sts_t sts,
    output mfrp_pkg::mfrp_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_QUOT = 3'd1;
    localparam logic [2:0] ST_MULT = 3'd2;
    localparam logic [2:0] ST_FIX  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (sts.in_valid)
                begin
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                cmd.calc_q = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.calc_m = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.calc_s = 1'b1;
                state_next = sts.empty ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                // one header per cycle while the output register has room
                if (!sts.out_stall)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_pkt)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last_pkt) |=> (state_reg == ST_IDLE))
        else $error("frame end did not return controller to idle");

    a_stall_holds_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && sts.out_stall) |=> (state_reg == ST_EMIT))
        else $error("controller left emit state under output stall");

endmodule

// File: rtl/mfrp_dp.sv
module mfrp_dp #(
    parameter int MAX_PACKETS = 64,
    parameter int SLICE_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mfrp_pkg::mfrp_cmd_t cmd,
    output mfrp_pkg::mfrp_sts_t sts,
    mfrp_in_if.sink             frames,
    mfrp_out_if.source          packets,
    mfrp_cfg_if.sink            cfg
);

    localparam int CntW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(MAX_PACKETS - 1);
    localparam int RecipShift = 31;
    // floor(2^31 / slice): quotient of a 16-bit room is at most one low
    localparam logic [31:0] SliceRecip = 32'((64'd1 << RecipShift) / SLICE_BYTES);
    localparam logic [mfrp_pkg::LenW-1:0] SliceLen = mfrp_pkg::LenW'(SLICE_BYTES);

    // Configuration registers
    logic [mfrp_pkg::MtuW-1:0]  mtu_reg;
    logic [mfrp_pkg::HdrW-1:0]  hdr_reg;
    logic [mfrp_pkg::PtW-1:0]   pt_reg;
    logic [mfrp_pkg::SsrcW-1:0] ssrc_reg;
    logic [31:0]                tstart_reg;
    logic [31:0]                ticks_reg;

    // Running state
    logic [mfrp_pkg::AccumW-1:0] accum_reg;
    logic [mfrp_pkg::AccumW-1:0] accum_next;
    logic [mfrp_pkg::SeqW-1:0]   seq_reg;

    // Per frame working registers
    logic [mfrp_pkg::BytesW-1:0] bytes_reg;
    logic [mfrp_pkg::BytesW-1:0] bytes_next;
    logic [mfrp_pkg::PicW-1:0]   ptype_reg;
    logic [mfrp_pkg::TsW-1:0]    ts_reg;
    logic [mfrp_pkg::TsW-1:0]    ts_next;
    logic [mfrp_pkg::MtuW-1:0]   room_reg;
    logic [mfrp_pkg::MtuW-1:0]   room_next;
    logic [mfrp_pkg::LenW-1:0]   quot_reg;
    logic [mfrp_pkg::LenW-1:0]   mult_reg;
    logic [mfrp_pkg::LenW-1:0]   sliced_reg;
    logic [mfrp_pkg::LenW-1:0]   sliced_next;
    logic [CntW-1:0]             cnt_reg;

    // Output register
    logic                        out_valid_reg;
    logic [mfrp_pkg::SeqW-1:0]   out_seq_reg;
    logic [mfrp_pkg::TsW-1:0]    out_ts_reg;
    logic [mfrp_pkg::SsrcW-1:0]  out_ssrc_reg;
    logic [mfrp_pkg::PtW-1:0]    out_pt_reg;
    logic [mfrp_pkg::PicW-1:0]   out_pic_reg;
    logic [mfrp_pkg::LenW-1:0]   out_len_reg;
    logic                        out_marker_reg;
    logic                        out_trunc_reg;
    logic                        out_last_reg;

    logic                        accept;
    logic [47:0]                 quot_prod;
    logic [31:0]                 mult_prod;
    logic [mfrp_pkg::LenW-1:0]   slice_rem;
    logic                        big;
    logic [mfrp_pkg::BytesW-1:0] bytes_after;
    logic [mfrp_pkg::LenW-1:0]   pkt_len;
    logic                        pkt_last;
    logic                        pkt_trunc;

    assign frames.ready = cmd.take;
    assign accept       = cmd.take && frames.valid;
    assign cfg.ready    = 1'b1;

    // Status back to the controller
    assign sts.in_valid  = frames.valid;
    assign sts.empty     = (bytes_reg == '0);
    assign sts.last_pkt  = pkt_last;
    assign sts.out_stall = out_valid_reg && !packets.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg    <= mfrp_pkg::MTU_RESET;
            hdr_reg    <= mfrp_pkg::HDR_RESET;
            pt_reg     <= mfrp_pkg::PT_RESET;
            ssrc_reg   <= '0;
            tstart_reg <= '0;
            ticks_reg  <= mfrp_pkg::TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mfrp_pkg::CFG_MTU:       mtu_reg    <= cfg.data[mfrp_pkg::MtuW-1:0];
                mfrp_pkg::CFG_HEADER:    hdr_reg    <= cfg.data[mfrp_pkg::HdrW-1:0];
                mfrp_pkg::CFG_PAYLOAD:   pt_reg     <= cfg.data[mfrp_pkg::PtW-1:0];
                mfrp_pkg::CFG_SOURCE_ID: ssrc_reg   <= cfg.data;
                mfrp_pkg::CFG_TS_START:  tstart_reg <= cfg.data;
                mfrp_pkg::CFG_TICKS:     ticks_reg  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Frame setup: room, timestamp, accumulator step
    always_comb
    begin
        if (mtu_reg > mfrp_pkg::MtuW'(hdr_reg))
        begin
            room_next = mtu_reg - mfrp_pkg::MtuW'(hdr_reg);
        end
        else
        begin
            room_next = '0;
        end
        ts_next    = tstart_reg + accum_reg[47:16];
        accum_next = accum_reg + mfrp_pkg::AccumW'(ticks_reg);
    end

    // Room rounded down to the slice size: reciprocal multiply, then correct
    assign quot_prod   = room_reg * SliceRecip;
    assign mult_prod   = quot_reg * SliceLen;
    assign slice_rem   = room_reg - mult_reg;
    assign sliced_next = (slice_rem >= SliceLen) ? (mult_reg + SliceLen) : mult_reg;

    // Packet split for the current header
    always_comb
    begin
        big = bytes_reg > mfrp_pkg::BytesW'(room_reg);
        if (big)
        begin
            bytes_after = bytes_reg - mfrp_pkg::BytesW'(sliced_reg);
            pkt_len     = sliced_reg;
        end
        else
        begin
            bytes_after = '0;
            pkt_len     = bytes_reg[mfrp_pkg::LenW-1:0];
        end
        pkt_trunc  = (cnt_reg == CntLast) && (bytes_after != '0);
        pkt_last   = (bytes_after == '0) || (cnt_reg == CntLast);
        bytes_next = accept ? frames.frame_bits[mfrp_pkg::FrameBitsW-1:3] : bytes_after;
    end

    // Running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                accum_reg <= accum_next;
            end
            if (cmd.emit)
            begin
                seq_reg <= seq_reg + 1'b1;
            end
        end
    end

    // Per frame working registers
    always_ff @(posedge clk)
    begin
        if (accept || cmd.emit)
        begin
            bytes_reg <= bytes_next;
        end
        if (accept)
        begin
            ptype_reg <= mfrp_pkg::kind_of_letter(frames.picture_letter);
            ts_reg    <= ts_next;
            room_reg  <= room_next;
            cnt_reg   <= '0;
        end
        else if (cmd.emit)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.calc_q)
        begin
            quot_reg <= quot_prod[RecipShift+mfrp_pkg::LenW-1:RecipShift];
        end
        if (cmd.calc_m)
        begin
            mult_reg <= mult_prod[mfrp_pkg::LenW-1:0];
        end
        if (cmd.calc_s)
        begin
            sliced_reg <= sliced_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (packets.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_seq_reg    <= seq_reg;
            out_ts_reg     <= ts_reg;
            out_ssrc_reg   <= ssrc_reg;
            out_pt_reg     <= pt_reg;
            out_pic_reg    <= ptype_reg;
            out_len_reg    <= pkt_len;
            out_marker_reg <= (bytes_after == '0);
            out_trunc_reg  <= pkt_trunc;
            out_last_reg   <= pkt_last;
        end
    end

    assign packets.valid            = out_valid_reg;
    assign packets.sequence_number  = out_seq_reg;
    assign packets.time_stamp       = out_ts_reg;
    assign packets.ssrc_out         = out_ssrc_reg;
    assign packets.payload_type_out = out_pt_reg;
    assign packets.picture_type     = out_pic_reg;
    assign packets.payload_length   = out_len_reg;
    assign packets.marker           = out_marker_reg;
    assign packets.truncated        = out_trunc_reg;
    assign packets.last             = out_last_reg;

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_marker_reg) |-> out_last_reg)
        else $error("marker packet not flagged last");

    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_trunc_reg) |-> (out_last_reg && !out_marker_reg))
        else $error("truncated packet must be last and carry no marker");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !packets.ready))
        else $error("header issued into a stalled output register");

endmodule

// File: rtl/mpeg_frame_rtp_packetizer.sv
// MPEG frame to RTP header packetizer. Each accepted frame descriptor (size in
// bits, picture letter) is split into packet headers whose payload is the MTU
// room less header bytes, rounded down to SLICE_BYTES, with the remainder in
// the final packet that carries the marker. At most MAX_PACKETS headers are
// issued per frame; leftover bytes are dropped and the last header is flagged
// truncated. A frame of N headers (N up to MAX_PACKETS) goes through an accept
// step, a reciprocal multiply, a multiply by the slice size and a one-step
// correction that derive the sliced room, then one header per cycle from the
// output register, slowed only by output back-pressure. A frame under one
// byte issues no header but still advances the timestamp. Configuration
// writes are registered at the next clock edge.
module mpeg_frame_rtp_packetizer #(
    parameter int MAX_PACKETS = 64,
    parameter int SLICE_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    mfrp_in_if.sink    frames,
    mfrp_out_if.source packets,
    mfrp_cfg_if.sink   cfg
);

    mfrp_pkg::mfrp_cmd_t cmd;
    mfrp_pkg::mfrp_sts_t sts;

    mfrp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    mfrp_dp #(
        .MAX_PACKETS (MAX_PACKETS),
        .SLICE_BYTES (SLICE_BYTES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .frames  (frames),
        .packets (packets),
        .cfg     (cfg)
    );

endmodule
